// ----- sv/fcv_pkg.sv -----
// Package for the frame CRC validator: constants, beat types and the CRC byte update.
`timescale 1ns / 1ps
`default_nettype none

package fcv_pkg;

    // Frame layout and limits
    localparam int HEADER_BYTES    = 12;
    localparam int MAX_FRAME_BYTES = 4096;

    // Field widths fixed by the status format
    localparam int COUNT_W = 13;

    localparam logic [COUNT_W-1:0] MIN_LEN   = COUNT_W'(HEADER_BYTES + 2);
    localparam logic [COUNT_W-1:0] MAX_LEN   = COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] SAT_COUNT = COUNT_W'(MAX_FRAME_BYTES + 1);

    // Header byte positions
    localparam logic [COUNT_W-1:0] POS_MAGIC_LO = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_MAGIC_HI = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_CHAN_LO  = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] POS_CHAN_HI  = COUNT_W'(9);

    // CRC16-CCITT parameters
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fcv_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] frame_bytes;
        logic               too_long;
        logic               length_ok;
        logic               magic_ok;
        logic               crc_ok;
        logic [15:0]        chan_count;
        logic [15:0]        computed_crc;
        logic [15:0]        stored_crc;
    } fcv_out_t;

    // One byte of CRC16, MSB first, eight shift steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/frame_crc_validator.sv -----
// Frame CRC validator top level: byte intake, header capture, CRC and status register.
`timescale 1ns / 1ps
`default_nettype none

// Takes a frame one byte per beat and, on the beat flagged last_byte, gives one
// status beat: saturated length, length, magic and CRC checks, the channel count
// from bytes 8-9, and the computed CRC (all bytes but the last two, CRC16-CCITT,
// init 0xFFFF, MSB first) next to the stored little-endian trailer. One byte is
// accepted every clock unless byte_stall is high; the rate is set by the unrolled
// eight-bit CRC update that sits between the frame state registers. The status beat
// appears the cycle after the last byte and waits in an output register; byte_stall
// rises only while that register is full and status_stall is high. The expected
// magic is loaded through magic_we/magic_data and applies at the next last byte.
module frame_crc_validator
    import fcv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire fcv_in_t  byte_beat,
    output logic          status_valid,
    input  wire logic     status_stall,
    output fcv_out_t      status_beat,
    input  wire logic     magic_we,
    input  wire logic [15:0] magic_data
);

    logic [15:0]        magic_cfg_reg;
    logic [15:0]        crc_reg,      crc_next;
    logic [7:0]         held0_reg,    held0_next;
    logic [7:0]         held1_reg,    held1_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [15:0]        magic_reg,    magic_next;
    logic [15:0]        chan_reg,     chan_next;
    logic               status_valid_reg, status_valid_next;
    fcv_out_t           status_reg,   status_next;

    logic               accept;
    logic [COUNT_W-1:0] pos;
    logic [15:0]        crc_upd;
    logic [7:0]         held0_upd;
    logic [COUNT_W-1:0] count_upd;
    logic [15:0]        magic_upd;
    logic [15:0]        chan_upd;
    logic               too_long;
    logic               len_ok;
    logic [15:0]        stored;

    // Handshake
    assign byte_stall   = status_valid_reg && status_stall;
    assign accept       = byte_valid && !byte_stall;
    assign status_valid = status_valid_reg;
    assign status_beat  = status_reg;

    // Per-byte frame update
    always_comb
    begin
        pos       = count_reg;
        crc_upd   = (pos >= COUNT_W'(2)) ? crc_byte(crc_reg, held0_reg) : crc_reg;
        held0_upd = held1_reg;
        magic_upd = magic_reg;
        chan_upd  = chan_reg;
        if (pos == POS_MAGIC_LO)
            magic_upd[7:0] = byte_beat.data_byte;
        if (pos == POS_MAGIC_HI)
            magic_upd[15:8] = byte_beat.data_byte;
        if (pos == POS_CHAN_LO)
            chan_upd[7:0] = byte_beat.data_byte;
        if (pos == POS_CHAN_HI)
            chan_upd[15:8] = byte_beat.data_byte;
        count_upd = (pos < SAT_COUNT) ? pos + COUNT_W'(1) : pos;

        // Status terms from the updated frame state
        too_long = count_upd > MAX_LEN;
        len_ok   = count_upd >= MIN_LEN;
        // held1 is still zero after a one-byte frame, so this covers that case too
        stored   = {byte_beat.data_byte, held1_reg};

        status_next.frame_bytes   = too_long ? MAX_LEN : count_upd;
        status_next.too_long      = too_long;
        status_next.length_ok     = len_ok;
        status_next.magic_ok      = (magic_upd == magic_cfg_reg);
        status_next.crc_ok        = len_ok && (crc_upd == stored);
        status_next.chan_count    = chan_upd;
        status_next.computed_crc  = crc_upd;
        status_next.stored_crc    = stored;

        // Frame state: clear after the last byte
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        magic_next = magic_reg;
        chan_next  = chan_reg;
        if (accept)
        begin
            if (byte_beat.last_byte)
            begin
                crc_next   = CRC_INIT;
                held0_next = '0;
                held1_next = '0;
                count_next = '0;
                magic_next = '0;
                chan_next  = '0;
            end
            else
            begin
                crc_next   = crc_upd;
                held0_next = held0_upd;
                held1_next = byte_beat.data_byte;
                count_next = count_upd;
                magic_next = magic_upd;
                chan_next  = chan_upd;
            end
        end

        // Output register occupancy
        status_valid_next = status_valid_reg && status_stall;
        if (accept && byte_beat.last_byte)
            status_valid_next = 1'b1;
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_cfg_reg    <= '0;
            crc_reg          <= CRC_INIT;
            held0_reg        <= '0;
            held1_reg        <= '0;
            count_reg        <= '0;
            magic_reg        <= '0;
            chan_reg         <= '0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (magic_we)
                magic_cfg_reg <= magic_data;
            crc_reg          <= crc_next;
            held0_reg        <= held0_next;
            held1_reg        <= held1_next;
            count_reg        <= count_next;
            magic_reg        <= magic_next;
            chan_reg         <= chan_next;
            status_valid_reg <= status_valid_next;
        end
    end

    // Status payload, loaded on the last byte
    always_ff @(posedge clk)
    begin
        if (accept && byte_beat.last_byte)
            status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ----- sv/fcv_checker.sv -----
// Port-level checker for the frame CRC validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fcv_checker
    import fcv_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_stall,
    input wire fcv_in_t     byte_beat,
    input wire logic        status_valid,
    input wire logic        status_stall,
    input wire fcv_out_t    status_beat,
    input wire logic        magic_we,
    input wire logic [15:0] magic_data
);

    // A stalled status beat holds
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_stall |=> status_valid && $stable(status_beat))
        else $error("status beat changed while stalled");

    // A new status beat follows an accepted last byte
    a_status_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status_valid) |-> $past(byte_valid && !byte_stall && byte_beat.last_byte))
        else $error("status beat without a last byte");

    // CRC pass needs a long enough frame
    a_crc_len: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_beat.crc_ok |-> status_beat.length_ok)
        else $error("crc_ok without length_ok");

    // Overlong frames report the saturated length
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_beat.too_long |-> status_beat.frame_bytes == MAX_LEN)
        else $error("overlong frame length not saturated");

endmodule

bind frame_crc_validator fcv_checker u_fcv_checker (.*);

`default_nettype wire

// ----- tb/fcv_status_checker.sv -----
// Frame CRC validator checker: follows accepted byte beats, predicts each status beat, compares.
`timescale 1ns / 1ps

module fcv_status_checker
    import fcv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  fcv_in_t     byte_beat,
    input  logic        status_valid,
    input  logic        status_stall,
    input  fcv_out_t    status_beat,
    input  logic        magic_we,
    input  logic [15:0] magic_data,
    output int          status_seen,
    output int          fail_count
);

    // Shadow of the magic register and of the frame in progress
    logic [15:0] magic_reg;
    logic [15:0] crc_run;
    logic [7:0]  hold_old;
    logic [7:0]  hold_new;
    int          byte_total;
    logic [15:0] magic_got;
    logic [15:0] chan_got;

    // Status beats predicted but not yet received, oldest first
    fcv_out_t    status_due[$];
    int          seen_cnt;
    int          err_cnt;

    // CRC16-CCITT, one byte, bit-serial: feedback is crc msb xor data bit
    function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic restart_frame();
        crc_run    = CRC_INIT;
        hold_old   = 8'h00;
        hold_new   = 8'h00;
        byte_total = 0;
        magic_got  = 16'h0000;
        chan_got   = 16'h0000;
    endtask

    task automatic cmp_field(input string nm, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, nm, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fcv_out_t    want;
        logic [15:0] stored;
        int          pos;
        if (!rst_n)
        begin
            magic_reg = 16'h0000;
            restart_frame();
            status_due.delete();
            seen_cnt    = 0;
            err_cnt     = 0;
            status_seen <= 0;
            fail_count  <= 0;
        end
        else
        begin
            // Status side first: a beat leaving now belongs to an earlier frame
            if (status_valid && !status_stall)
            begin
                seen_cnt++;
                if (status_due.size() == 0)
                begin
                    $display("%0t: status beat with no frame pending, actual %h",
                             $time, status_beat);
                    err_cnt++;
                end
                else
                begin
                    want = status_due.pop_front();
                    cmp_field("frame_bytes", 16'(want.frame_bytes),
                              16'(status_beat.frame_bytes));
                    cmp_field("too_long", 16'(want.too_long), 16'(status_beat.too_long));
                    cmp_field("length_ok", 16'(want.length_ok), 16'(status_beat.length_ok));
                    cmp_field("magic_ok", 16'(want.magic_ok), 16'(status_beat.magic_ok));
                    cmp_field("crc_ok", 16'(want.crc_ok), 16'(status_beat.crc_ok));
                    cmp_field("chan_count", want.chan_count, status_beat.chan_count);
                    cmp_field("computed_crc", want.computed_crc, status_beat.computed_crc);
                    cmp_field("stored_crc", want.stored_crc, status_beat.stored_crc);
                end
            end

            // Byte side: bytes older than the last two go into the CRC
            if (byte_valid && !byte_stall)
            begin
                pos = byte_total;
                if (pos >= 2)
                    crc_run = ccitt_next(crc_run, hold_old);
                hold_old = hold_new;
                hold_new = byte_beat.data_byte;

                // header capture, little-endian
                if (pos == POS_MAGIC_LO)
                    magic_got[7:0] = byte_beat.data_byte;
                else if (pos == POS_MAGIC_HI)
                    magic_got[15:8] = byte_beat.data_byte;
                else if (pos == POS_CHAN_LO)
                    chan_got[7:0] = byte_beat.data_byte;
                else if (pos == POS_CHAN_HI)
                    chan_got[15:8] = byte_beat.data_byte;

                // count stops one past the maximum
                if (pos <= MAX_FRAME_BYTES)
                    byte_total = pos + 1;

                if (byte_beat.last_byte)
                begin
                    if (byte_total < 2)
                        stored = {byte_beat.data_byte, 8'h00};
                    else
                        stored = {hold_new, hold_old};
                    want.too_long      = (byte_total > MAX_FRAME_BYTES);
                    want.frame_bytes   = want.too_long ? COUNT_W'(MAX_FRAME_BYTES)
                                                       : COUNT_W'(byte_total);
                    want.length_ok     = (byte_total >= HEADER_BYTES + 2);
                    want.magic_ok      = (magic_got == magic_reg);
                    want.crc_ok        = want.length_ok && (crc_run == stored);
                    want.chan_count    = chan_got;
                    want.computed_crc  = crc_run;
                    want.stored_crc    = stored;
                    status_due.push_back(want);
                    restart_frame();
                end
            end

            // register write applies from the next last byte on
            if (magic_we)
                magic_reg = magic_data;

            status_seen <= seen_cnt;
            fail_count  <= err_cnt;
        end
    end

endmodule

// ----- tb/tb_frame_crc_validator.sv -----
// Testbench top for the frame CRC validator: clock, reset, frame stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_frame_crc_validator;
    import fcv_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_LEN     = 400;
    localparam int SETTLE       = 8;
    localparam int PHASE_BYTES  = 310;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    fcv_in_t     byte_beat    = '0;
    logic        status_valid;
    logic        status_stall = 1'b0;
    fcv_out_t    status_beat;
    logic        magic_we     = 1'b0;
    logic [15:0] magic_data   = 16'h0000;

    int          status_seen;
    int          fail_count;
    int          frames_sent   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_off      = 1'b0;
    int          hold_cycles   = 0;
    int          cycle_count   = 0;
    int          idle_plan[4]  = '{0, 51, 0, 32};
    int          stall_plan[4] = '{0, 0, 51, 32};
    logic [7:0]  frame_q[$];
    logic [15:0] magic_now;

    always #(CLK_HALF) clk = ~clk;

    frame_crc_validator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_beat    (byte_beat),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status_beat  (status_beat),
        .magic_we     (magic_we),
        .magic_data   (magic_data)
    );

    fcv_status_checker i_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_beat    (byte_beat),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status_beat  (status_beat),
        .magic_we     (magic_we),
        .magic_data   (magic_data),
        .status_seen  (status_seen),
        .fail_count   (fail_count)
    );

    // Receiver: one long hold-off when asked, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_off && hold_cycles < HOLD_LEN)
        begin
            status_stall <= 1'b1;
            hold_cycles  <= hold_cycles + 1;
        end
        else
            status_stall <= ($urandom_range(99) < stall_pct);
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Frame with correct trailer CRC; header fields placed at their offsets
    task automatic build_good_frame(input int len, input logic [15:0] magic,
                                    input logic [15:0] chans);
        logic [15:0] crc;
        logic [7:0]  b;
        frame_q.delete();
        crc = CRC_INIT;
        for (int i = 0; i < len - 2; i++)
        begin
            if (i == POS_MAGIC_LO)
                b = magic[7:0];
            else if (i == POS_MAGIC_HI)
                b = magic[15:8];
            else if (i == POS_CHAN_LO)
                b = chans[7:0];
            else if (i == POS_CHAN_HI)
                b = chans[15:8];
            else
                b = 8'($urandom);
            frame_q.push_back(b);
            crc = crc_byte(crc, b);
        end
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endtask

    // Offer frame_q one beat at a time, random gaps before each beat
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            byte_beat  <= fcv_in_t'{data_byte: frame_q[i],
                                    last_byte: (i == frame_q.size() - 1)};
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
        end
        frames_sent++;
    endtask

    // Sender pauses until every status beat is back, then lets the block settle
    task automatic wait_for_status();
        byte_valid <= 1'b0;
        while (status_seen < frames_sent)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_magic(input logic [15:0] value);
        magic_we   <= 1'b1;
        magic_data <= value;
        @(posedge clk);
        magic_we   <= 1'b0;
    endtask

    initial
    begin
        int kind;
        int len;
        int idx;
        int phase_bytes;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short frames against a zero magic: missing header bytes read as zero
        load_magic(16'h0000);
        frame_q = '{8'h00};
        send_frame();
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'h00, 8'hFF};
        send_frame();
        build_good_frame(MIN_LEN - 1, 16'h0000, 16'h0000);
        send_frame();
        build_good_frame(MIN_LEN, 16'h0000, 16'h0000);
        send_frame();
        wait_for_status();

        // All-ones magic and a bad trailer
        load_magic(16'hFFFF);
        build_good_frame(MIN_LEN, 16'hFFFF, 16'hFFFF);
        send_frame();
        frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h80;
        send_frame();
        wait_for_status();

        // Random frames, one magic setting and one idling mix per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_plan[ph];
            stall_pct     <= stall_plan[ph];
            magic_now     = 16'($urandom);
            load_magic(magic_now);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                kind = $urandom_range(99);
                if ($urandom_range(19) == 0)
                    len = $urandom_range(MIN_LEN, 300);
                else
                    len = $urandom_range(MIN_LEN, MIN_LEN + 30);
                if (kind < 60)
                    build_good_frame(len, magic_now, 16'($urandom));
                else if (kind < 72)
                begin
                    // single bit error anywhere in the frame
                    build_good_frame(len, magic_now, 16'($urandom));
                    idx = $urandom_range(frame_q.size() - 1);
                    frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(7));
                end
                else if (kind < 82)
                    build_good_frame(len, 16'($urandom), 16'($urandom));
                else
                begin
                    // noise, often shorter than a header
                    len = $urandom_range(1, MIN_LEN + 10);
                    frame_q.delete();
                    repeat (len) frame_q.push_back(8'($urandom));
                end
                phase_bytes += frame_q.size();
                send_frame();
            end
            wait_for_status();
        end

        // Receiver holds off while frames keep coming, so the input backs up
        send_idle_pct = 0;
        stall_pct     <= 0;
        hold_off      <= 1'b1;
        repeat (6)
        begin
            build_good_frame($urandom_range(MIN_LEN, MIN_LEN + 10), magic_now, 16'($urandom));
            send_frame();
        end
        wait_for_status();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/fcv_pkg.sv
sv/frame_crc_validator.sv
sv/fcv_checker.sv
tb/fcv_status_checker.sv
tb/tb_frame_crc_validator.sv
